FILE: hw/rtl/cspop_pkg.sv
// Shared types and character constants for the control stream pane output parser.
package cspop_pkg;

    typedef enum logic [2:0] {
        ST_GROUND    = 3'd0,
        ST_TOKEN     = 3'd1,
        ST_OUT_BEGIN = 3'd2,
        ST_OUTPUT    = 3'd3,
        ST_PANE      = 3'd4,
        ST_OUT_END   = 3'd5,
        ST_NOTIFY    = 3'd6,
        ST_ERROR     = 3'd7
    } t_state;

    localparam logic [15:0] CH_LF     = 16'h000A;
    localparam logic [15:0] CH_CR     = 16'h000D;
    localparam logic [15:0] CH_SPACE  = 16'h0020;
    localparam logic [15:0] CH_PCT    = 16'h0025;
    localparam logic [15:0] CH_BSLASH = 16'h005C;
    localparam logic [15:0] CH_ZERO   = 16'h0030;
    localparam logic [15:0] CH_NINE   = 16'h0039;

    localparam logic KIND_PANE   = 1'b0;
    localparam logic KIND_NOTIFY = 1'b1;

    localparam logic [2:0] CAND_ALL   = 3'b111;
    localparam logic [2:0] LEN_BEGIN  = 3'd5;
    localparam logic [2:0] LEN_END    = 3'd3;
    localparam logic [2:0] LEN_OUTPUT = 3'd6;
    localparam logic [2:0] LEN_MAX    = 3'd7;

    // One queue record: all results caused by one input character.
    typedef struct packed {
        logic        kind;
        logic [15:0] pane;
        logic [15:0] val0;
        logic [15:0] val1;
        logic        two;
    } t_rec;

    function automatic logic [15:0] kw_begin_char(input logic [2:0] pos);
        logic [15:0] ch;
        case (pos)
            3'd0:    ch = 16'h0062;
            3'd1:    ch = 16'h0065;
            3'd2:    ch = 16'h0067;
            3'd3:    ch = 16'h0069;
            3'd4:    ch = 16'h006E;
            default: ch = 16'h0000;
        endcase
        return ch;
    endfunction

    function automatic logic [15:0] kw_end_char(input logic [2:0] pos);
        logic [15:0] ch;
        case (pos)
            3'd0:    ch = 16'h0065;
            3'd1:    ch = 16'h006E;
            3'd2:    ch = 16'h0064;
            default: ch = 16'h0000;
        endcase
        return ch;
    endfunction

    function automatic logic [15:0] kw_output_char(input logic [2:0] pos);
        logic [15:0] ch;
        case (pos)
            3'd0:    ch = 16'h006F;
            3'd1:    ch = 16'h0075;
            3'd2:    ch = 16'h0074;
            3'd3:    ch = 16'h0070;
            3'd4:    ch = 16'h0075;
            3'd5:    ch = 16'h0074;
            default: ch = 16'h0000;
        endcase
        return ch;
    endfunction

endpackage

FILE: hw/rtl/cspop_front.sv
// Front end: accepts characters, runs the parse state machine and builds result records.
module cspop_front #(
    parameter int PANE_BITS = 16,
    parameter int CHAR_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [15:0]     i_character,
    input  logic            i_space,
    output logic            o_push,
    output cspop_pkg::t_rec o_rec
);
    import cspop_pkg::*;

    localparam int PW = (PANE_BITS > 16) ? PANE_BITS : 16;
    localparam int CW = (CHAR_BITS > 16) ? CHAR_BITS : 16;

    t_state                 r_state, n_state;
    logic [2:0]             r_kw_len, n_kw_len;
    logic [2:0]             r_cand, n_cand;
    logic [PANE_BITS-1:0]   r_pane, n_pane;
    logic                   r_done, n_done;
    logic                   r_esc_act, n_esc_act;
    logic [CHAR_BITS-1:0]   r_esc_val, n_esc_val;

    logic                   accept;
    logic [15:0]            c;
    logic [15:0]            c_off;
    logic [3:0]             digit;
    logic                   is_digit;
    logic [PANE_BITS+3:0]   pane_prod;
    logic [PANE_BITS-1:0]   pane_sat;
    logic [CHAR_BITS+3:0]   esc_prod;
    logic [CHAR_BITS-1:0]   esc_sat;
    logic [PW-1:0]          pane_ext;
    logic [CW-1:0]          esc_ext;
    logic                   m_begin, m_end, m_output;
    logic                   tok_begin, tok_end, tok_output;
    logic [2:0]             kw_len_inc;

    assign accept   = i_valid && i_space;
    assign o_ready  = i_space;
    assign c        = i_character;
    assign c_off    = c - CH_ZERO;
    assign digit    = c_off[3:0];
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);

    assign pane_prod = ({4'b0000, r_pane} << 3) + ({4'b0000, r_pane} << 1)
                     + {{PANE_BITS{1'b0}}, digit};
    assign pane_sat  = (|pane_prod[PANE_BITS+3:PANE_BITS]) ? {PANE_BITS{1'b1}}
                                                           : pane_prod[PANE_BITS-1:0];
    assign esc_prod  = ({4'b0000, r_esc_val} << 3) + {{CHAR_BITS{1'b0}}, digit};
    assign esc_sat   = (|esc_prod[CHAR_BITS+3:CHAR_BITS]) ? {CHAR_BITS{1'b1}}
                                                          : esc_prod[CHAR_BITS-1:0];
    assign pane_ext  = PW'(r_pane);
    assign esc_ext   = CW'(r_esc_val);

    assign m_begin    = r_cand[0] && (r_kw_len < LEN_BEGIN) && (c == kw_begin_char(r_kw_len));
    assign m_end      = r_cand[1] && (r_kw_len < LEN_END) && (c == kw_end_char(r_kw_len));
    assign m_output   = r_cand[2] && (r_kw_len < LEN_OUTPUT)
                     && (c == kw_output_char(r_kw_len));
    assign tok_begin  = r_cand[0] && (r_kw_len == LEN_BEGIN);
    assign tok_end    = r_cand[1] && (r_kw_len == LEN_END);
    assign tok_output = r_cand[2] && (r_kw_len == LEN_OUTPUT);
    assign kw_len_inc = (r_kw_len == LEN_MAX) ? r_kw_len : r_kw_len + 3'd1;

    always_comb begin
        n_state = r_state;
        if (accept) begin
            unique case (r_state)
                ST_GROUND: begin
                    if (c == CH_PCT) n_state = ST_TOKEN;
                end
                ST_TOKEN: begin
                    if (c == CH_SPACE) begin
                        if (tok_begin)       n_state = ST_OUT_BEGIN;
                        else if (tok_end)    n_state = ST_OUT_END;
                        else if (tok_output) n_state = ST_PANE;
                        else                 n_state = ST_NOTIFY;
                    end else if (c == CH_LF) begin
                        n_state = ST_GROUND;
                    end else if (c == CH_PCT) begin
                        n_state = ST_ERROR;
                    end
                end
                ST_OUT_BEGIN: begin
                    if (c == CH_LF) n_state = ST_OUTPUT;
                end
                ST_OUTPUT: begin
                    if (c == CH_PCT)     n_state = ST_TOKEN;
                    else if (c == CH_LF) n_state = ST_GROUND;
                end
                ST_PANE: begin
                    if (c != CH_PCT && !is_digit && !(!r_done && c == CH_SPACE)
                        && c != CH_BSLASH && c == CH_CR) n_state = ST_GROUND;
                end
                ST_OUT_END, ST_NOTIFY: begin
                    if (c == CH_LF) n_state = ST_GROUND;
                end
                ST_ERROR: n_state = ST_ERROR;
                default:  n_state = ST_ERROR;
            endcase
        end
    end

    always_comb begin
        n_kw_len   = r_kw_len;
        n_cand     = r_cand;
        n_pane     = r_pane;
        n_done     = r_done;
        n_esc_act  = r_esc_act;
        n_esc_val  = r_esc_val;
        o_push     = 1'b0;
        o_rec.kind = KIND_PANE;
        o_rec.pane = pane_ext[15:0];
        o_rec.val0 = c;
        o_rec.val1 = c;
        o_rec.two  = 1'b0;
        if (accept) begin
            unique case (r_state)
                ST_GROUND: begin
                    if (c == CH_PCT) begin
                        n_kw_len = '0;
                        n_cand   = CAND_ALL;
                    end
                end
                ST_TOKEN: begin
                    if (c == CH_SPACE) begin
                        if (!tok_begin && !tok_end && tok_output) begin
                            n_pane = '0;
                            n_done = 1'b0;
                        end
                    end else if (c == CH_LF) begin
                        n_kw_len = '0;
                        n_cand   = CAND_ALL;
                        n_pane   = '0;
                        n_done   = 1'b0;
                    end else if (c != CH_PCT) begin
                        n_cand   = {m_output, m_end, m_begin};
                        n_kw_len = kw_len_inc;
                    end
                end
                ST_OUTPUT: begin
                    if (c == CH_PCT) begin
                        n_kw_len = '0;
                        n_cand   = CAND_ALL;
                    end else if (c == CH_LF) begin
                        n_kw_len = '0;
                        n_cand   = CAND_ALL;
                        n_pane   = '0;
                        n_done   = 1'b0;
                    end
                end
                ST_PANE: begin
                    if (c == CH_PCT) begin
                        n_done = r_done;
                    end else if (is_digit) begin
                        if (!r_done) begin
                            n_pane = pane_sat;
                        end else if (r_esc_act) begin
                            n_esc_val = esc_sat;
                        end else begin
                            o_push = 1'b1;
                        end
                    end else if (!r_done && c == CH_SPACE) begin
                        n_done = 1'b1;
                    end else if (c == CH_BSLASH) begin
                        n_esc_val = '0;
                        n_esc_act = 1'b1;
                    end else begin
                        // pending escape value goes out ahead of the character
                        if (r_esc_act) begin
                            n_esc_act  = 1'b0;
                            o_push     = 1'b1;
                            o_rec.val0 = esc_ext[15:0];
                            o_rec.two  = (c != CH_CR);
                        end else if (c != CH_CR) begin
                            o_push = 1'b1;
                        end
                        if (c == CH_CR) begin
                            n_kw_len = '0;
                            n_cand   = CAND_ALL;
                            n_pane   = '0;
                            n_done   = 1'b0;
                        end
                    end
                end
                ST_OUT_END: begin
                    if (c == CH_LF) begin
                        n_kw_len = '0;
                        n_cand   = CAND_ALL;
                        n_pane   = '0;
                        n_done   = 1'b0;
                    end
                end
                ST_NOTIFY: begin
                    if (c == CH_LF) begin
                        o_push     = 1'b1;
                        o_rec.kind = KIND_NOTIFY;
                        o_rec.pane = '0;
                        o_rec.val0 = '0;
                        n_kw_len   = '0;
                        n_cand     = CAND_ALL;
                        n_pane     = '0;
                        n_done     = 1'b0;
                    end
                end
                default: begin
                    n_done = r_done;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_GROUND;
            r_kw_len  <= '0;
            r_cand    <= CAND_ALL;
            r_pane    <= '0;
            r_done    <= 1'b0;
            r_esc_act <= 1'b0;
            r_esc_val <= '0;
        end else begin
            r_state   <= n_state;
            r_kw_len  <= n_kw_len;
            r_cand    <= n_cand;
            r_pane    <= n_pane;
            r_done    <= n_done;
            r_esc_act <= n_esc_act;
            r_esc_val <= n_esc_val;
        end
    end

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ERROR |=> r_state == ST_ERROR)
        else $error("error state left");
    a_no_push_unaccepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> accept)
        else $error("record pushed without a transfer");
    a_notify_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_rec.kind == KIND_NOTIFY |-> !o_rec.two && r_state == ST_NOTIFY)
        else $error("bad notification record");

endmodule

FILE: hw/rtl/cspop_queue.sv
// Record queue between the parser front end and the output back end.
module cspop_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cspop_pkg::t_rec i_rec,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output cspop_pkg::t_rec o_rec
);
    import cspop_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_rec          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rec   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop)      n_count = r_count + CW'(1);
        else if (!i_push && i_pop) n_count = r_count - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            if (i_pop)  r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule

FILE: hw/rtl/cspop_back.sv
// Back end: output register that walks through the one or two results of each record.
module cspop_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  cspop_pkg::t_rec i_rec,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_kind,
    output logic [15:0]     o_pane_number,
    output logic [15:0]     o_char_value,
    output logic            o_last
);
    import cspop_pkg::*;

    t_rec r_rec;
    logic r_valid;
    logic r_phase;
    logic done_cur;

    assign o_last        = !r_rec.two || r_phase;
    assign done_cur      = r_valid && i_ready && o_last;
    assign o_pop         = !i_empty && (!r_valid || done_cur);
    assign o_valid       = r_valid;
    assign o_kind        = r_rec.kind;
    assign o_pane_number = r_rec.pane;
    assign o_char_value  = r_phase ? r_rec.val1 : r_rec.val0;

    always_ff @(posedge i_clk) begin
        if (o_pop) r_rec <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_phase <= 1'b0;
        end else if (done_cur) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (r_valid && i_ready) begin
            r_phase <= 1'b1;
        end
    end

    a_phase_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> r_valid && r_rec.two)
        else $error("second result without a two-result record");
    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_ready && !o_last |=> r_valid && r_phase)
        else $error("second result lost");
    a_pop_on_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !r_valid || done_cur)
        else $error("record loaded over a pending result");

endmodule

FILE: hw/rtl/control_stream_pane_output_parser.sv
// Top level of the control stream pane output parser: front end, record queue, back end.
//
//  channel | direction | handshake                 | payload
//  input   | in        | i_in_valid / o_in_ready   | i_character
//  output  | out       | o_out_valid / i_out_ready | o_kind, o_pane_number, o_char_value, o_last
//
// One character per cycle is taken while the record queue (QUEUE_DEPTH records) has room.
// A character's first result is written to a queue entry and then loaded into the output register.
// The output register gives one result per cycle while i_out_ready is high, so a character
// with two results holds the output for both in turn; that port sets the sustained result rate.
// Reset clears parser state, queue pointers and the output valid flag; no clearing pass.
// A stalled output fills the queue, after which o_in_ready drops.
module control_stream_pane_output_parser #(
    parameter int PANE_BITS   = 16,
    parameter int CHAR_BITS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_character,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [15:0] o_pane_number,
    output logic [15:0] o_char_value,
    output logic        o_last
);
    import cspop_pkg::*;

    logic push;
    logic full;
    logic pop;
    logic empty;
    t_rec front_rec;
    t_rec head_rec;

    cspop_front #(
        .PANE_BITS (PANE_BITS),
        .CHAR_BITS (CHAR_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_character (i_character),
        .i_space     (!full),
        .o_push      (push),
        .o_rec       (front_rec)
    );

    cspop_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_rec   (head_rec)
    );

    cspop_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_rec         (head_rec),
        .o_pop         (pop),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_kind        (o_kind),
        .o_pane_number (o_pane_number),
        .o_char_value  (o_char_value),
        .o_last        (o_last)
    );

endmodule

FILE: tb/control_stream_pane_output_parser_test.sv
// Self-checking testbench for the control stream pane output parser: directed and random streams.
`timescale 1ns / 100ps

module control_stream_pane_output_parser_test;
    import cspop_pkg::*;

    typedef struct {
        logic        kind;
        logic [15:0] pane;
        logic [15:0] value;
        logic        last;
    } t_pane_result;

    class t_pane_result_tracker;
        t_state       state;
        logic [2:0]   kw_len;
        logic [2:0]   kw_cand;
        logic [15:0]  pane_acc;
        bit           pane_done;
        bit           esc_on;
        logic [15:0]  esc_val;
        string        keywords[3];
        t_pane_result pending_results[$];
        int           errors;
        int           transfers;
        int           results;
        int           notifications;

        function new();
            // candidate bit 0 begin, bit 1 end, bit 2 output
            keywords[0] = "begin";
            keywords[1] = "end";
            keywords[2] = "output";
            to_ground();
            esc_on  = 1'b0;
            esc_val = '0;
        endfunction

        function void to_ground();
            state     = ST_GROUND;
            kw_len    = '0;
            kw_cand   = CAND_ALL;
            pane_acc  = '0;
            pane_done = 1'b0;
        endfunction

        function void to_token();
            state   = ST_TOKEN;
            kw_len  = '0;
            kw_cand = CAND_ALL;
        endfunction

        function logic [15:0] saturate_digit(logic [15:0] acc, logic [15:0] c, int unsigned base);
            logic [31:0] v;
            v = 32'(acc) * base + 32'(c) - 32'(CH_ZERO);
            return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
        endfunction

        function bit keyword_hit(int k, logic [2:0] pos, logic [15:0] c);
            if (int'(pos) >= keywords[k].len())
                return 1'b0;
            return c == {8'h00, keywords[k][pos]};
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void take_char(logic [15:0] c);
            t_pane_result outs[$];
            logic [2:0]   cand;
            transfers++;
            case (state)
                ST_GROUND: begin
                    if (c == CH_PCT)
                        to_token();
                end
                ST_TOKEN: begin
                    if (c == CH_SPACE) begin
                        if (kw_cand[0] && kw_len == LEN_BEGIN) begin
                            state = ST_OUT_BEGIN;
                        end else if (kw_cand[1] && kw_len == LEN_END) begin
                            state = ST_OUT_END;
                        end else if (kw_cand[2] && kw_len == LEN_OUTPUT) begin
                            state     = ST_PANE;
                            pane_acc  = '0;
                            pane_done = 1'b0;
                        end else begin
                            state = ST_NOTIFY;
                        end
                    end else if (c == CH_LF) begin
                        to_ground();
                    end else if (c == CH_PCT) begin
                        state = ST_ERROR;
                    end else begin
                        cand = '0;
                        for (int k = 0; k < 3; k++)
                            if (kw_cand[k] && keyword_hit(k, kw_len, c))
                                cand[k] = 1'b1;
                        kw_cand = cand;
                        if (kw_len != LEN_MAX)
                            kw_len++;
                    end
                end
                ST_OUT_BEGIN: begin
                    if (c == CH_LF)
                        state = ST_OUTPUT;
                end
                ST_OUTPUT: begin
                    if (c == CH_PCT)
                        to_token();
                    else if (c == CH_LF)
                        to_ground();
                end
                ST_PANE: begin
                    if (c != CH_PCT) begin
                        if (c >= CH_ZERO && c <= CH_NINE) begin
                            if (!pane_done)
                                pane_acc = saturate_digit(pane_acc, c, 10);
                            else if (esc_on)
                                esc_val = saturate_digit(esc_val, c, 8);
                            else
                                outs.push_back('{KIND_PANE, pane_acc, c, 1'b0});
                        end else if (!pane_done && c == CH_SPACE) begin
                            pane_done = 1'b1;
                        end else if (c == CH_BSLASH) begin
                            esc_val = '0;
                            esc_on  = 1'b1;
                        end else begin
                            if (esc_on) begin
                                outs.push_back('{KIND_PANE, pane_acc, esc_val, 1'b0});
                                esc_on = 1'b0;
                            end
                            if (c == CH_CR)
                                to_ground();
                            else
                                outs.push_back('{KIND_PANE, pane_acc, c, 1'b0});
                        end
                    end
                end
                ST_OUT_END: begin
                    if (c == CH_LF)
                        to_ground();
                end
                ST_NOTIFY: begin
                    if (c == CH_LF) begin
                        outs.push_back('{KIND_NOTIFY, 16'h0000, 16'h0000, 1'b0});
                        notifications++;
                        to_ground();
                    end
                end
                default: ;
            endcase
            if (outs.size() > 0)
                outs[outs.size() - 1].last = 1'b1;
            foreach (outs[i])
                pending_results.push_back(outs[i]);
        endfunction

        function void check_result(logic kind, logic [15:0] pane, logic [15:0] value, logic last);
            t_pane_result want;
            results++;
            if (pending_results.size() == 0) begin
                $error("result with none expected: kind %0d pane %0d char_value %0h",
                       kind, pane, value);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, kind);
                errors++;
            end
            if (pane !== want.pane) begin
                $error("pane_number: expected %0d, got %0d", want.pane, pane);
                errors++;
            end
            if (value !== want.value) begin
                $error("char_value: expected %0h, got %0h", want.value, value);
                errors++;
            end
            if (last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [15:0] i_character;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_kind;
    logic [15:0] o_pane_number;
    logic [15:0] o_char_value;
    logic        o_last;

    t_pane_result_tracker tracker;
    int idle_mode;
    bit hold_off;
    bit allow_error;

    control_stream_pane_output_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_character   (i_character),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_pane_number (o_pane_number),
        .o_char_value  (o_char_value),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(400_000 * 20);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int draw_gap();
        case (idle_mode)
            0: return 0;
            1: return $urandom_range(0, 15);
            default: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 15)) : 0;
        endcase
    endfunction

    function automatic logic [15:0] digit_char();
        return 16'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic logic [15:0] junk_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return 16'($urandom_range(16'h21, 16'h7E));
        if (r == 7)
            return CH_SPACE;
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    // a '%' in a token would lock the parser up; kept back until the final phase
    task automatic send_char(input logic [15:0] c);
        int          gap;
        logic [15:0] ch;
        ch = c;
        if (!allow_error && tracker.state == ST_TOKEN && ch == CH_PCT)
            ch = 16'h0041;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_character <= ch;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.take_char(ch);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char({8'h00, s[i]});
    endtask

    task automatic send_junk(input int n);
        repeat (n) send_char(junk_char());
    endtask

    task automatic send_word();
        string names[8];
        int    pick;
        names = '{"beg", "begins", "en", "endx", "outpu", "outputs", "window-add",
                  "sessions-changed"};
        pick = $urandom_range(0, 12);
        if (pick < 8) begin
            send_text(names[pick]);
        end else if (pick < 11) begin
            repeat ($urandom_range(1, 10)) send_char(16'($urandom_range(16'h61, 16'h7A)));
        end else if (pick == 11) begin
            send_text("output");
            send_char(CH_CR);
        end
    endtask

    task automatic send_pane_line();
        int pick;
        int ndig;
        send_text("%output ");
        pick = $urandom_range(0, 19);
        ndig = (pick == 0) ? 0 : (pick == 1) ? 7 : $urandom_range(1, 3);
        repeat (ndig) send_char(digit_char());
        if ($urandom_range(0, 9) != 0)
            send_char(CH_SPACE);
        repeat ($urandom_range(0, 12)) begin
            pick = $urandom_range(0, 19);
            if (pick < 10) begin
                send_char(junk_char());
            end else if (pick < 13) begin
                send_char(digit_char());
            end else if (pick < 17) begin
                send_char(CH_BSLASH);
                repeat (($urandom_range(0, 9) == 0) ? 7 : $urandom_range(0, 4))
                    send_char(digit_char());
            end else if (pick == 17) begin
                send_char(CH_PCT);
            end else if (pick == 18) begin
                send_char(CH_LF);
            end else begin
                send_char(16'($urandom_range(0, 16'hFFFF)));
            end
        end
        if ($urandom_range(0, 9) != 0)
            send_char(CH_CR);
    endtask

    task automatic receive_results();
        int stall;
        forever begin
            if (hold_off) begin
                stall    = 300;
                hold_off = 1'b0;
            end else begin
                stall = draw_gap();
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            tracker.check_result(o_kind, o_pane_number, o_char_value, o_last);
        end
    endtask

    initial begin
        int  pick;
        int  next_switch;
        bit  pressed;
        bit  paused;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_character <= '0;
        i_out_ready <= 1'b0;
        tracker     = new();
        idle_mode   = 1;
        hold_off    = 1'b0;
        allow_error = 1'b0;
        pressed     = 1'b0;
        paused      = 1'b0;
        next_switch = 100;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            receive_results();
        join_none

        // saturated pane number, field extremes, escape digit nine, escape restart, CR, notification
        send_text("%output 99999 ");
        send_char(16'hFFFF);
        send_char(16'h0000);
        send_char(CH_BSLASH);
        send_char(16'h0039);
        send_char(CH_BSLASH);
        send_text("75");
        send_char(CH_CR);
        send_text("%z ");
        send_char(CH_LF);

        while (tracker.transfers < 650) begin
            if (tracker.transfers >= next_switch) begin
                idle_mode   = $urandom_range(0, 2);
                next_switch += 100;
            end
            if (!pressed && tracker.transfers >= 250) begin
                // output held off while the input keeps streaming
                pressed   = 1'b1;
                idle_mode = 0;
                hold_off  = 1'b1;
                send_text("%output 7 ");
                send_junk(40);
                send_char(CH_CR);
            end
            if (!paused && tracker.transfers >= 450) begin
                paused     = 1'b1;
                i_in_valid <= 1'b0;
                while (tracker.pending() != 0) @(posedge i_clk);
            end
            pick = $urandom_range(0, 19);
            if (pick < 9) begin
                send_pane_line();
            end else if (pick < 12) begin
                send_text("%begin ");
                send_junk($urandom_range(0, 4));
                send_char(CH_LF);
                if ($urandom_range(0, 1) != 0) begin
                    send_pane_line();
                end else begin
                    send_junk($urandom_range(0, 5));
                    send_char(CH_LF);
                end
                send_text("%end ");
                send_junk($urandom_range(0, 4));
                send_char(CH_LF);
            end else if (pick < 15) begin
                send_char(CH_PCT);
                send_word();
                send_char(CH_SPACE);
                send_junk($urandom_range(0, 6));
                send_char(CH_LF);
            end else if (pick == 15) begin
                send_char(CH_PCT);
                send_word();
                send_char(CH_LF);
            end else begin
                repeat ($urandom_range(1, 6)) send_char(16'($urandom_range(0, 16'hFFFF)));
            end
        end

        // back to ground from any state, then into the sticky error state
        send_char(CH_CR);
        send_char(CH_LF);
        send_char(CH_LF);
        allow_error = 1'b1;
        send_char(CH_PCT);
        send_char(CH_PCT);
        repeat (6) send_char(16'($urandom_range(0, 16'hFFFF)));
        send_pane_line();

        idle_mode  = 0;
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d characters over ground, keyword, block, pane and escape paths",
                 tracker.transfers);
        $display("Compared %0d results, %0d notification line ends, ending in the error state",
                 tracker.results, tracker.notifications);
        if (tracker.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/cspop_pkg.sv
hw/rtl/cspop_front.sv
hw/rtl/cspop_queue.sv
hw/rtl/cspop_back.sv
hw/rtl/control_stream_pane_output_parser.sv
tb/control_stream_pane_output_parser_test.sv
